>>> rtl/gsqi_pkg.sv
// gsqi_pkg: shared types and constants for the grid surface quad indexer
// no dependencies; imported by rtl/grid_surface_quad_indexer.sv and bench/grid_surface_quad_indexer_test.sv
package gsqi_pkg;

    localparam int ID_W    = 23;   // surface point id width
    localparam int SRC_W   = 30;   // source cell / grid point index width
    localparam int COORD_W = 10;   // face-local coordinate width
    localparam int CFG_W   = 11;   // widest configuration register
    localparam int FACE_W  = 3;
    localparam int CIDX_W  = 2;

    typedef logic [FACE_W-1:0] face_t;
    typedef logic [CIDX_W-1:0] cfg_idx_t;

    // face codes
    localparam face_t FACE_XLO = 3'd0;
    localparam face_t FACE_XHI = 3'd1;
    localparam face_t FACE_YLO = 3'd2;
    localparam face_t FACE_YHI = 3'd3;
    localparam face_t FACE_ZLO = 3'd4;
    localparam face_t FACE_ZHI = 3'd5;
    localparam face_t FACE_CNT = 3'd6;

    // request kinds
    localparam logic REQ_QUAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // register indexes
    localparam cfg_idx_t CFG_POINTS_X    = 2'd0;
    localparam cfg_idx_t CFG_POINTS_Y    = 2'd1;
    localparam cfg_idx_t CFG_POINTS_Z    = 2'd2;
    localparam cfg_idx_t CFG_CONSOLIDATE = 2'd3;

    // box quads over the eight corners, rows past the sixth are unused
    localparam logic [2:0] BOX_QUADS [8][4] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd0, 3'd4, 3'd5, 3'd1},
        '{3'd1, 3'd5, 3'd6, 3'd2},
        '{3'd2, 3'd6, 3'd7, 3'd3},
        '{3'd3, 3'd7, 3'd4, 3'd0},
        '{3'd4, 3'd7, 3'd6, 3'd5},
        '{3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd0, 3'd0, 3'd0}
    };

endpackage

>>> rtl/grid_surface_quad_indexer.sv
// grid_surface_quad_indexer: boundary quad and surface point indexing of a rectilinear grid
// depends on rtl/gsqi_pkg.sv
//
//   channel   signals                                  word
//   --------  ---------------------------------------  ---------------------------------
//   request   in_valid / in_stall                      req_type, face, coord_a, coord_b
//   result    out_valid / out_stall                    corner0..corner3, source_index,
//                                                      status
//   config    cfg_we, cfg_index, cfg_wdata             points_x/y/z, consolidate
//
// four register stages: input, decode, multiply, output; one word is taken every cycle
// while in_stall is low; the face decode ahead of stage two, the corner id and inner
// index multiplies ahead of stage three and the outer index multiply ahead of stage
// four set the per-stage depth
// rst_n clears valid bits and loads the default 2x2x2 grid, consolidation off
// each stage holds only while its successor is full and held, so bubbles are
// squeezed out and in_stall rises only when all four stages are full
module grid_surface_quad_indexer #(
    parameter int MAX_POINTS_PER_AXIS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  gsqi_pkg::cfg_idx_t            cfg_index,
    input  logic [gsqi_pkg::CFG_W-1:0]    cfg_wdata,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  gsqi_pkg::face_t               face,
    input  logic [gsqi_pkg::COORD_W-1:0]  coord_a,
    input  logic [gsqi_pkg::COORD_W-1:0]  coord_b,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gsqi_pkg::ID_W-1:0]     corner0,
    output logic [gsqi_pkg::ID_W-1:0]     corner1,
    output logic [gsqi_pkg::ID_W-1:0]     corner2,
    output logic [gsqi_pkg::ID_W-1:0]     corner3,
    output logic [gsqi_pkg::SRC_W-1:0]    source_index,
    output logic                          status
);
    import gsqi_pkg::*;

    // axis count width, wide enough for a coordinate plus one too
    localparam int CW = $clog2(MAX_POINTS_PER_AXIS + 1);
    localparam int LW = (CW > COORD_W + 1) ? CW : COORD_W + 1;

    function automatic logic [LW-1:0] clamp_axis(input logic [CFG_W-1:0] v);
        if (v == '0)
            return LW'(1);
        if (32'(v) > MAX_POINTS_PER_AXIS)
            return LW'(MAX_POINTS_PER_AXIS);
        return LW'(v);
    endfunction

    // configuration registers
    logic [LW-1:0] px_reg, py_reg, pz_reg;
    logic          cons_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg   <= LW'(2);
            py_reg   <= LW'(2);
            pz_reg   <= LW'(2);
            cons_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINTS_X:    px_reg   <= clamp_axis(cfg_wdata);
                CFG_POINTS_Y:    py_reg   <= clamp_axis(cfg_wdata);
                CFG_POINTS_Z:    pz_reg   <= clamp_axis(cfg_wdata);
                CFG_CONSOLIDATE: cons_reg <= cfg_wdata[0];
                default:         cons_reg <= cons_reg;
            endcase
        end
    end

    // grid-wide products, refreshed every cycle; ids wrap at the id width
    logic [ID_W-1:0] xy_reg, xz2_reg, yz2_reg;
    logic [ID_W-1:0] xy_next, xz2_next, yz2_next;

    always_comb
    begin
        xy_next  = ID_W'(px_reg) * ID_W'(py_reg);
        xz2_next = ID_W'(px_reg) * (ID_W'(pz_reg) - ID_W'(2));
        yz2_next = (ID_W'(py_reg) - ID_W'(2)) * (ID_W'(pz_reg) - ID_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xy_reg  <= ID_W'(4);
            xz2_reg <= '0;
            yz2_reg <= '0;
        end
        else
        begin
            xy_reg  <= xy_next;
            xz2_reg <= xz2_next;
            yz2_reg <= yz2_next;
        end
    end

    // stage flow control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !s4_valid_reg || !out_stall;
    assign adv3     = !s3_valid_reg || adv4;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    // stage 1: input word
    logic               s1_req_reg;
    face_t              s1_face_reg;
    logic [COORD_W-1:0] s1_a_reg, s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_req_reg  <= req_type;
            s1_face_reg <= face;
            s1_a_reg    <= coord_a;
            s1_b_reg    <= coord_b;
        end
    end

    // decode: every corner id becomes m1 * m2 + addend, the index two chained products
    logic [LW-1:0]   m1_next [4];
    logic [LW-1:0]   m2_next [4];
    logic [ID_W-1:0] add_next [4];
    logic [LW-1:0]   sz_next, sym_next, sy_next, sxm_next, sx_next;
    logic            rej_next;

    always_comb
    begin
        logic [LW-1:0]   a_w, b_w, na, nb, zm2, bx, by;
        logic [LW-1:0]   u, v, x, y, z;
        logic [ID_W-1:0] b_yhi, b_xlo, b_xhi;
        logic            wind, face_ok, ok, du, dv, solid;

        a_w   = LW'(s1_a_reg);
        b_w   = LW'(s1_b_reg);
        zm2   = pz_reg - LW'(2);
        bx    = (px_reg > LW'(1)) ? px_reg - LW'(1) : LW'(1);
        by    = (py_reg > LW'(1)) ? py_reg - LW'(1) : LW'(1);
        b_yhi = (xy_reg << 1) + xz2_reg;
        b_xlo = (xy_reg << 1) + (xz2_reg << 1);
        b_xhi = b_xlo + yz2_reg;
        solid = pz_reg > LW'(1);
        wind  = (s1_face_reg == FACE_XLO) || (s1_face_reg == FACE_YHI) ||
                (s1_face_reg == FACE_ZLO);

        if (s1_face_reg == FACE_XLO || s1_face_reg == FACE_XHI)
        begin
            na = py_reg;
            nb = pz_reg;
        end
        else if (s1_face_reg == FACE_YLO || s1_face_reg == FACE_YHI)
        begin
            na = px_reg;
            nb = pz_reg;
        end
        else
        begin
            na = px_reg;
            nb = py_reg;
        end

        face_ok = (s1_face_reg < FACE_CNT) &&
                  !(s1_face_reg == FACE_XHI && px_reg <= LW'(1)) &&
                  !(s1_face_reg == FACE_YHI && py_reg <= LW'(1)) &&
                  !(s1_face_reg == FACE_ZHI && pz_reg <= LW'(1));

        if (cons_reg)
        begin
            if (s1_req_reg == REQ_POINT)
                ok = solid || (s1_face_reg < 3'd4);
            else
                ok = solid ? (s1_face_reg < FACE_CNT) : (s1_face_reg == 3'd0);
        end
        else if (s1_req_reg == REQ_POINT)
            ok = face_ok && (a_w < na) && (b_w < nb);
        else
            ok = face_ok && (a_w + LW'(1) < na) && (b_w + LW'(1) < nb);

        x = '0;
        y = '0;
        z = '0;
        for (int k = 0; k < 4; k++)
        begin
            // corner offsets on the face, winding set by the face
            du = (k == 2) || (k == 1 && !wind) || (k == 3 && wind);
            dv = (k == 2) || (k == 1 && wind) || (k == 3 && !wind);
            u  = a_w + LW'(du);
            v  = b_w + LW'(dv);
            case (s1_face_reg)
                FACE_XLO: begin x = '0;                   y = u; z = v; end
                FACE_XHI: begin x = px_reg - LW'(1);      y = u; z = v; end
                FACE_YLO: begin x = u; y = '0;                   z = v; end
                FACE_YHI: begin x = u; y = py_reg - LW'(1);      z = v; end
                FACE_ZLO: begin x = u; y = v; z = '0;                  end
                default:  begin x = u; y = v; z = pz_reg - LW'(1);     end
            endcase

            // owning face: z-low, z-high, y-low, y-high, then the x sides
            if (z == '0)
            begin
                m1_next[k]  = x;
                m2_next[k]  = py_reg;
                add_next[k] = ID_W'(y);
            end
            else if (z == pz_reg - LW'(1))
            begin
                m1_next[k]  = x;
                m2_next[k]  = py_reg;
                add_next[k] = xy_reg + ID_W'(y);
            end
            else if (y == '0)
            begin
                m1_next[k]  = x;
                m2_next[k]  = zm2;
                add_next[k] = (xy_reg << 1) + ID_W'(z) - ID_W'(1);
            end
            else if (y == py_reg - LW'(1))
            begin
                m1_next[k]  = x;
                m2_next[k]  = zm2;
                add_next[k] = b_yhi + ID_W'(z) - ID_W'(1);
            end
            else
            begin
                m1_next[k]  = y - LW'(1);
                m2_next[k]  = zm2;
                add_next[k] = ((s1_face_reg == FACE_XHI) ? b_xhi : b_xlo) +
                              ID_W'(z) - ID_W'(1);
            end

            if (cons_reg)
            begin
                m1_next[k] = '0;
                m2_next[k] = '0;
                if (s1_req_reg == REQ_QUAD)
                    add_next[k] = ID_W'(BOX_QUADS[s1_face_reg][k]);
                else
                    add_next[k] = (k == 0) ? ID_W'(s1_face_reg) : '0;
            end
            else if (s1_req_reg == REQ_POINT && k != 0)
            begin
                m1_next[k]  = '0;
                m2_next[k]  = '0;
                add_next[k] = '0;
            end

            if (!ok)
            begin
                m1_next[k]  = '0;
                m2_next[k]  = '0;
                add_next[k] = '0;
            end
        end

        // source index operands: ((sz * sym) + sy) * sxm + sx
        sym_next = py_reg;
        sxm_next = px_reg;
        if (cons_reg)
        begin
            sx_next = (s1_face_reg[1:0] == 2'd1 || s1_face_reg[1:0] == 2'd2) ?
                      px_reg - LW'(1) : '0;
            sy_next = s1_face_reg[1] ? py_reg - LW'(1) : '0;
            sz_next = s1_face_reg[2] ? pz_reg - LW'(1) : '0;
            if (s1_req_reg == REQ_QUAD)
            begin
                sx_next = '0;
                sy_next = '0;
                sz_next = '0;
            end
        end
        else if (s1_req_reg == REQ_POINT)
        begin
            case (s1_face_reg)
                FACE_XLO: begin sx_next = '0;              sy_next = a_w; sz_next = b_w; end
                FACE_XHI: begin sx_next = px_reg - LW'(1); sy_next = a_w; sz_next = b_w; end
                FACE_YLO: begin sx_next = a_w; sy_next = '0;              sz_next = b_w; end
                FACE_YHI: begin sx_next = a_w; sy_next = py_reg - LW'(1); sz_next = b_w; end
                FACE_ZLO: begin sx_next = a_w; sy_next = b_w; sz_next = '0;              end
                default:  begin sx_next = a_w; sy_next = b_w; sz_next = pz_reg - LW'(1); end
            endcase
        end
        else
        begin
            sym_next = by;
            sxm_next = bx;
            case (s1_face_reg)
                FACE_XLO: begin sx_next = '0;              sy_next = a_w; sz_next = b_w; end
                FACE_XHI: begin sx_next = px_reg - LW'(2); sy_next = a_w; sz_next = b_w; end
                FACE_YLO: begin sx_next = a_w; sy_next = '0;              sz_next = b_w; end
                FACE_YHI: begin sx_next = a_w; sy_next = py_reg - LW'(2); sz_next = b_w; end
                FACE_ZLO: begin sx_next = a_w; sy_next = b_w; sz_next = '0;              end
                default:  begin sx_next = a_w; sy_next = b_w; sz_next = pz_reg - LW'(2); end
            endcase
        end

        if (!ok)
        begin
            sx_next = '0;
            sy_next = '0;
            sz_next = '0;
        end
        rej_next = !ok;
    end

    // stage 2: decoded operands
    logic [LW-1:0]   s2_m1_reg [4];
    logic [LW-1:0]   s2_m2_reg [4];
    logic [ID_W-1:0] s2_add_reg [4];
    logic [LW-1:0]   s2_sz_reg, s2_sym_reg, s2_sy_reg, s2_sxm_reg, s2_sx_reg;
    logic            s2_rej_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_m1_reg  <= m1_next;
            s2_m2_reg  <= m2_next;
            s2_add_reg <= add_next;
            s2_sz_reg  <= sz_next;
            s2_sym_reg <= sym_next;
            s2_sy_reg  <= sy_next;
            s2_sxm_reg <= sxm_next;
            s2_sx_reg  <= sx_next;
            s2_rej_reg <= rej_next;
        end
    end

    // stage 3: corner ids and the inner index term
    logic [ID_W-1:0]  s3_cor_reg [4];
    logic [ID_W-1:0]  cor_next [4];
    logic [SRC_W-1:0] s3_t_reg, t_next;
    logic [LW-1:0]    s3_sxm_reg, s3_sx_reg;
    logic             s3_rej_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            cor_next[k] = ID_W'(s2_m1_reg[k]) * ID_W'(s2_m2_reg[k]) + s2_add_reg[k];
        t_next = SRC_W'(s2_sz_reg) * SRC_W'(s2_sym_reg) + SRC_W'(s2_sy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_cor_reg <= cor_next;
            s3_t_reg   <= t_next;
            s3_sxm_reg <= s2_sxm_reg;
            s3_sx_reg  <= s2_sx_reg;
            s3_rej_reg <= s2_rej_reg;
        end
    end

    // stage 4: output word
    logic [ID_W-1:0]  s4_cor_reg [4];
    logic [SRC_W-1:0] s4_src_reg, src_next;
    logic             s4_status_reg;

    assign src_next = s3_t_reg * SRC_W'(s3_sxm_reg) + SRC_W'(s3_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv4)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            s4_cor_reg    <= s3_cor_reg;
            s4_src_reg    <= src_next;
            s4_status_reg <= s3_rej_reg;
        end
    end

    assign out_valid    = s4_valid_reg;
    assign corner0      = s4_cor_reg[0];
    assign corner1      = s4_cor_reg[1];
    assign corner2      = s4_cor_reg[2];
    assign corner3      = s4_cor_reg[3];
    assign source_index = s4_src_reg;
    assign status       = s4_status_reg;

    // a rejected word carries nothing but its status
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && s4_status_reg |-> s4_cor_reg[0] == '0 && s4_cor_reg[1] == '0 &&
            s4_cor_reg[2] == '0 && s4_cor_reg[3] == '0 && s4_src_reg == '0)
        else $error("rejected word with nonzero payload");

    // requests are held off only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg)
        else $error("input held off with a free stage");

    // a held middle stage keeps its word
    a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !adv3 |=> s3_valid_reg && $stable(s3_t_reg))
        else $error("stage three word lost while held");

    // a decode-stage word moves on to stage three in the next cycle once stage three can advance
    a_flow_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && adv3 && !s1_valid_reg |=> s3_valid_reg)
        else $error("decoded word did not advance");

endmodule

>>> bench/grid_surface_quad_indexer_test.sv
// grid_surface_quad_indexer_test: checks quad and surface point indexing against a local predictor
// depends on rtl/gsqi_pkg.sv and rtl/grid_surface_quad_indexer.sv
`timescale 1ns / 1ps

module grid_surface_quad_indexer_test;
    import gsqi_pkg::*;

    // one request word and one result word
    typedef struct packed {
        logic                rtype;
        face_t               fc;
        logic [COORD_W-1:0]  ca;
        logic [COORD_W-1:0]  cb;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0]  c0;
        logic [ID_W-1:0]  c1;
        logic [ID_W-1:0]  c2;
        logic [ID_W-1:0]  c3;
        logic [SRC_W-1:0] src;
        logic             st;
    } surface_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    cfg_idx_t            cfg_index = CFG_POINTS_X;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                req_type = REQ_QUAD;
    face_t               face = FACE_XLO;
    logic [COORD_W-1:0]  coord_a = '0;
    logic [COORD_W-1:0]  coord_b = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [ID_W-1:0]     corner0, corner1, corner2, corner3;
    logic [SRC_W-1:0]    source_index;
    logic                status;

    grid_surface_quad_indexer DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .face(face), .coord_a(coord_a), .coord_b(coord_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .corner0(corner0), .corner1(corner1), .corner2(corner2), .corner3(corner3),
        .source_index(source_index), .status(status)
    );

    always #4 clk = ~clk;

    // predictor's own copy of the registers
    longint gx = 2, gy = 2, gz = 2;
    bit     merge = 1'b0;

    request_t pending_reqs[$];
    surface_t expected_words[$];
    int       errors = 0;
    longint   cycles = 0;
    int       accepted = 0;
    int       queued = 0;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       in_taken = 1'b0;

    // surface ids: z-low, z-high, y-low, y-high, x-low, x-high
    function automatic longint id_zlo(longint x, longint y);
        return x * gy + y;
    endfunction

    function automatic longint id_zhi(longint x, longint y);
        return gx * gy + x * gy + y;
    endfunction

    function automatic longint id_ylo(longint x, longint z);
        if (z == 0) return id_zlo(x, 0);
        if (z == gz - 1) return id_zhi(x, 0);
        return 2 * gx * gy + x * (gz - 2) + z - 1;
    endfunction

    function automatic longint id_yhi(longint x, longint z);
        if (z == 0) return id_zlo(x, gy - 1);
        if (z == gz - 1) return id_zhi(x, gy - 1);
        return 2 * gx * gy + gx * (gz - 2) + x * (gz - 2) + z - 1;
    endfunction

    function automatic longint id_xside(longint xs, longint y, longint z, longint base);
        if (z == 0) return id_zlo(xs, y);
        if (z == gz - 1) return id_zhi(xs, y);
        if (y == 0) return id_ylo(xs, z);
        if (y == gy - 1) return id_yhi(xs, z);
        return base + (y - 1) * (gz - 2) + z - 1;
    endfunction

    function automatic longint surface_id(face_t f, longint a, longint b);
        longint xlo_base;
        xlo_base = 2 * gx * gy + 2 * gx * (gz - 2);
        case (f)
            FACE_XLO: return id_xside(0, a, b, xlo_base);
            FACE_XHI: return id_xside(gx - 1, a, b, xlo_base + (gy - 2) * (gz - 2));
            FACE_YLO: return id_ylo(a, b);
            FACE_YHI: return id_yhi(a, b);
            FACE_ZLO: return id_zlo(a, b);
            default:  return id_zhi(a, b);
        endcase
    endfunction

    function automatic surface_t index_request(request_t q);
        surface_t r;
        longint a, b, na, nb, cx, cy, cz, bx, by;
        int fi;
        bit solid;
        r = '0;
        r.st = 1'b1;
        a = q.ca;
        b = q.cb;
        fi = q.fc;
        if (merge) begin
            solid = gz > 1;
            if (q.rtype == REQ_QUAD) begin
                if (fi < (solid ? 6 : 1)) begin
                    r.c0 = BOX_QUADS[fi][0];
                    r.c1 = BOX_QUADS[fi][1];
                    r.c2 = BOX_QUADS[fi][2];
                    r.c3 = BOX_QUADS[fi][3];
                    r.st = 1'b0;
                end
            end else if (fi < (solid ? 8 : 4)) begin
                cx = ((fi % 4) == 1 || (fi % 4) == 2) ? gx - 1 : 0;
                cy = ((fi % 4) >= 2) ? gy - 1 : 0;
                cz = (fi >= 4) ? gz - 1 : 0;
                r.c0 = ID_W'(fi);
                r.src = SRC_W'((cz * gy + cy) * gx + cx);
                r.st = 1'b0;
            end
        end else if (fi < 6 && !((q.fc == FACE_XHI && gx <= 1) ||
                                 (q.fc == FACE_YHI && gy <= 1) ||
                                 (q.fc == FACE_ZHI && gz <= 1))) begin
            if (fi < 2) begin na = gy; nb = gz; end
            else if (fi < 4) begin na = gx; nb = gz; end
            else begin na = gx; nb = gy; end
            if (q.rtype == REQ_POINT) begin
                if (a < na && b < nb) begin
                    r.c0 = ID_W'(surface_id(q.fc, a, b));
                    if (fi < 2) begin cx = (q.fc == FACE_XHI) ? gx - 1 : 0; cy = a; cz = b; end
                    else if (fi < 4) begin cx = a; cy = (q.fc == FACE_YHI) ? gy - 1 : 0; cz = b; end
                    else begin cx = a; cy = b; cz = (q.fc == FACE_ZHI) ? gz - 1 : 0; end
                    r.src = SRC_W'((cz * gy + cy) * gx + cx);
                    r.st = 1'b0;
                end
            end else if (a + 1 < na && b + 1 < nb) begin
                bx = gx > 1 ? gx - 1 : 1;
                by = gy > 1 ? gy - 1 : 1;
                r.c0 = ID_W'(surface_id(q.fc, a, b));
                r.c2 = ID_W'(surface_id(q.fc, a + 1, b + 1));
                // winding flips between the two face groups
                if (q.fc == FACE_XLO || q.fc == FACE_YHI || q.fc == FACE_ZLO) begin
                    r.c1 = ID_W'(surface_id(q.fc, a, b + 1));
                    r.c3 = ID_W'(surface_id(q.fc, a + 1, b));
                end else begin
                    r.c1 = ID_W'(surface_id(q.fc, a + 1, b));
                    r.c3 = ID_W'(surface_id(q.fc, a, b + 1));
                end
                if (fi < 2) begin cx = (q.fc == FACE_XHI) ? gx - 2 : 0; cy = a; cz = b; end
                else if (fi < 4) begin cx = a; cy = (q.fc == FACE_YHI) ? gy - 2 : 0; cz = b; end
                else begin cx = a; cy = b; cz = (q.fc == FACE_ZHI) ? gz - 2 : 0; end
                r.src = SRC_W'((cz * by + cy) * bx + cx);
                r.st = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic longint clamp_axis(logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    // no gap mostly, otherwise a short one, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver: next word goes up at the falling edge after acceptance, unless a gap is pending
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    request_t q;
                    q = pending_reqs.pop_front();
                    req_type <= q.rtype;
                    face <= q.fc;
                    coord_a <= q.ca;
                    coord_b <= q.cb;
                    in_valid <= 1'b1;
                    gap_left <= gap_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            // receiver stall pattern
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                hold_left <= gap_len();
                out_stall <= 1'b0;
            end
        end
    end

    // monitor: prediction made at acceptance, results checked in order
    always @(posedge clk) begin
        cycles <= cycles + 1;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            expected_words.push_back(index_request({req_type, face, coord_a, coord_b}));
            accepted <= accepted + 1;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                surface_t e;
                e = expected_words.pop_front();
                if (corner0 !== e.c0) begin
                    $error("corner0 expected %0d actual %0d", e.c0, corner0);
                    errors++;
                end
                if (corner1 !== e.c1) begin
                    $error("corner1 expected %0d actual %0d", e.c1, corner1);
                    errors++;
                end
                if (corner2 !== e.c2) begin
                    $error("corner2 expected %0d actual %0d", e.c2, corner2);
                    errors++;
                end
                if (corner3 !== e.c3) begin
                    $error("corner3 expected %0d actual %0d", e.c3, corner3);
                    errors++;
                end
                if (source_index !== e.src) begin
                    $error("source_index expected %0d actual %0d", e.src, source_index);
                    errors++;
                end
                if (status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
            end
        end
    end

    // timeout guard
    always @(posedge clk) begin
        if (cycles > 400000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POINTS_X: gx = clamp_axis(val);
            CFG_POINTS_Y: gy = clamp_axis(val);
            CFG_POINTS_Z: gz = clamp_axis(val);
            default:      merge = val[0];
        endcase
    endtask

    task automatic set_grid(logic [CFG_W-1:0] px, logic [CFG_W-1:0] py,
                            logic [CFG_W-1:0] pz, logic cons);
        write_reg(CFG_POINTS_X, px);
        write_reg(CFG_POINTS_Y, py);
        write_reg(CFG_POINTS_Z, pz);
        write_reg(CFG_CONSOLIDATE, CFG_W'(cons));
    endtask

    task automatic push_req(logic rt, face_t f, logic [COORD_W-1:0] a,
                            logic [COORD_W-1:0] b);
        pending_reqs.push_back({rt, f, a, b});
        queued++;
    endtask

    // let the pipe drain and the expected results empty, then idle on the clock
    task automatic drain();
        wait (pending_reqs.size() == 0 && accepted == queued);
        while (expected_words.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly in-range coordinates on the current grid, some wild ones
    task automatic random_burst(int n);
        longint lim;
        logic [COORD_W-1:0] a, b;
        face_t f;
        logic rt;
        for (int i = 0; i < n; i++) begin
            rt = 1'($urandom_range(0, 1));
            f = $urandom_range(0, 99) < 90 ? face_t'($urandom_range(0, 5))
                                           : face_t'($urandom_range(6, 7));
            lim = (f < FACE_YLO) ? gy : gx;
            if ($urandom_range(0, 99) < 80) a = COORD_W'($urandom_range(0, int'(lim) - 1));
            else a = COORD_W'($urandom);
            lim = (f < FACE_ZLO) ? gz : gy;
            if ($urandom_range(0, 99) < 80) b = COORD_W'($urandom_range(0, int'(lim) - 1));
            else b = COORD_W'($urandom);
            push_req(rt, f, a, b);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset grid: every face and kind, plus both invalid face codes
        for (int f = 0; f < 8; f++) begin
            push_req(REQ_QUAD, face_t'(f), 0, 0);
            push_req(REQ_POINT, face_t'(f), 1, 1);
        end
        push_req(REQ_QUAD, FACE_ZLO, 1, 0);
        push_req(REQ_POINT, FACE_XLO, 10'h3FF, 10'h3FF);
        drain();

        // largest grid with corner coordinates
        set_grid(11'h7FF, 11'd1024, 11'd1024, 1'b0);
        push_req(REQ_QUAD, FACE_XHI, 10'd1022, 10'd1022);
        push_req(REQ_POINT, FACE_ZHI, 10'h3FF, 10'h3FF);
        push_req(REQ_QUAD, FACE_YHI, 10'h3FF, 10'd0);
        push_req(REQ_POINT, FACE_XHI, 10'd512, 10'd300);
        random_burst(150);
        drain();

        // degenerate and flat grids, empty high faces
        set_grid(11'd0, 11'd1, 11'd1, 1'b0);
        random_burst(60);
        drain();
        set_grid(11'd7, 11'd5, 11'd1, 1'b0);
        random_burst(150);
        drain();

        // consolidation, solid and flat
        set_grid(11'd9, 11'd4, 11'd6, 1'b1);
        for (int f = 0; f < 8; f++) begin
            push_req(REQ_QUAD, face_t'(f), 10'h3FF, 0);
            push_req(REQ_POINT, face_t'(f), 0, 10'h3FF);
        end
        random_burst(80);
        drain();
        write_reg(CFG_POINTS_Z, 11'd1);
        random_burst(60);
        drain();

        // small random 3d grids
        write_reg(CFG_CONSOLIDATE, 11'd0);
        for (int g = 0; g < 7; g++) begin
            set_grid(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                     CFG_W'($urandom_range(1, 12)), 1'b0);
            random_burst(110);
            drain();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
